[src/strip_cluster_time_projection_defines.svh]
// Assertion macros shared by the strip cluster time projection block.
`ifndef STRIP_CLUSTER_TIME_PROJECTION_DEFINES_SVH
`define STRIP_CLUSTER_TIME_PROJECTION_DEFINES_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define SCTP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising clock edge outside reset.
`define SCTP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/sctp_pkg.sv]
// Shared constants and widths for the strip cluster time projection block.
package sctp_pkg;

  localparam int MAX_CLUSTER_STRIPS = 64;

  localparam int CH_W    = 13;
  localparam int POS_W   = 22;
  localparam int DRIFT_W = 13;
  localparam int CHG_W   = 16;
  localparam int TAN_W   = 16;
  localparam int HOLE_W  = 4;
  localparam int HGAP_W  = 13;
  localparam int OCHG_W  = 22;
  localparam int OSIZE_W = 7;

  localparam int OCHG_MAX  = 2**OCHG_W - 1;
  localparam int OSIZE_MAX = 2**OSIZE_W - 1;
  localparam int POS_MAX   = 2**(POS_W-1) - 1;
  localparam int POS_MIN   = -(2**(POS_W-1));

  localparam int LOG_MAX = $clog2(MAX_CLUSTER_STRIPS);
  localparam int CNT_W   = $clog2(MAX_CLUSTER_STRIPS + 1);
  localparam int SQ_W    = CHG_W + LOG_MAX;
  localparam int SPQ_W   = POS_W + CHG_W + LOG_MAX;
  localparam int SDQ_W   = DRIFT_W + CHG_W + LOG_MAX;
  localparam int MEAN_W  = POS_W + 1;

  localparam int DIV_W     = SPQ_W;
  localparam int DIV_CNT_W = $clog2(DIV_W);
  localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(DIV_W - 1);

  localparam int CPROD_W   = TAN_W + DRIFT_W + 2;
  localparam int CORR_W    = CPROD_W - 16 + 2;
  localparam int CRND_HALF = 32768;

  localparam int CFG_W     = 13;
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_HOLE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HALF_GAP = 1'd1;

  localparam logic [HOLE_W-1:0] MAX_HOLE_RST = 4'd1;
  localparam logic [HGAP_W-1:0] HALF_GAP_RST = 13'd2580;

  localparam int LCNT_W = 2;
  localparam logic [LCNT_W-1:0] LCNT_TWO = 2'd2;

endpackage

[src/strip_cluster_time_projection.sv]
// Top level of the strip clustering block with drift-time position correction.
// Strips of one layer arrive one item at a time in channel order; the block takes
// no new item (in_stall high) until the current one is fully handled. For each
// emitted cluster the serial divider forms the charge-weighted mean position and
// mean drift one quotient bit per cycle (skipped when the cluster charge is zero),
// and the result is held while out_stall is high. At most two results follow one
// strip; last_of_run marks the final one.
`include "strip_cluster_time_projection_defines.svh"

module strip_cluster_time_projection (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_wr_en,
  input  logic [sctp_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [sctp_pkg::CFG_W-1:0]          cfg_wdata,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [sctp_pkg::CH_W-1:0]           in_strip_channel,
  input  logic signed [sctp_pkg::POS_W-1:0]   in_strip_pos,
  input  logic [sctp_pkg::DRIFT_W-1:0]        in_drift_dist,
  input  logic [sctp_pkg::CHG_W-1:0]          in_strip_charge,
  input  logic signed [sctp_pkg::TAN_W-1:0]   in_tan_theta,
  input  logic                                in_even_gap,
  input  logic                                in_layer_end,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [sctp_pkg::POS_W-1:0]   out_cluster_position,
  output logic [sctp_pkg::OCHG_W-1:0]         out_cluster_charge,
  output logic [sctp_pkg::OSIZE_W-1:0]        out_cluster_size,
  output logic [sctp_pkg::CH_W-1:0]           out_first_channel,
  output logic                                out_last_of_run
);
  import sctp_pkg::*;

  typedef enum logic [10:0] {
    S_IDLE = 11'b00000000001,
    S_MUL  = 11'b00000000010,
    S_ACC  = 11'b00000000100,
    S_DSET = 11'b00000001000,
    S_DPOS = 11'b00000010000,
    S_DDRF = 11'b00000100000,
    S_CMUL = 11'b00001000000,
    S_CRND = 11'b00010000000,
    S_SAT  = 11'b00100000000,
    S_OUT  = 11'b01000000000,
    S_CLR  = 11'b10000000000
  } state_t;

  state_t state_r, state_nxt;

  // configuration
  logic [HOLE_W-1:0] max_hole_r;
  logic [HGAP_W-1:0] half_gap_r;

  // layer and cluster state
  logic signed [SPQ_W-1:0] sum_pos_r;
  logic [SDQ_W-1:0]        sum_drift_r;
  logic [SQ_W-1:0]         sum_charge_r;
  logic [CH_W-1:0]         prev_channel_r;
  logic [CH_W-1:0]         first_channel_r;
  logic [CNT_W-1:0]        open_size_r;
  logic [LCNT_W-1:0]       lcnt_r;
  logic signed [TAN_W-1:0] tan_h_r;
  logic                    even_h_r;

  // sequencer flags
  logic phase_r;
  logic end_r;
  logic end_emit_r;

  // latched item
  logic [CH_W-1:0]         ch_r;
  logic signed [POS_W-1:0] pos_r;
  logic [DRIFT_W-1:0]      drift_r;
  logic [CHG_W-1:0]        q_r;
  logic signed [TAN_W-1:0] tan_r;
  logic                    even_r;

  // datapath
  logic signed [POS_W+CHG_W:0]     pprod_r;
  logic [DRIFT_W+CHG_W-1:0]        dprod_r;
  logic                            neg_r;
  logic signed [MEAN_W-1:0]        mean_pos_r;
  logic [DRIFT_W-1:0]              mean_drift_r;
  logic signed [CPROD_W-1:0]       cprod_r;
  logic signed [CORR_W-1:0]        corr_r;

  // result register
  logic signed [POS_W-1:0] opos_r;
  logic [OCHG_W-1:0]       ochg_r;
  logic [OSIZE_W-1:0]      osize_r;
  logic [CH_W-1:0]         ofirst_r;
  logic                    olast_r;

  logic in_accept;
  logic out_accept;

  logic signed [CH_W:0] chan_diff;
  logic signed [CH_W:0] hole_lim;
  logic                 full;
  logic                 close_now;
  logic [LCNT_W-1:0]    lcnt_after;
  logic                 end_emit_now;

  logic                 spq_neg;
  logic [SPQ_W-1:0]     spq_mag;
  logic [SQ_W-1:0]      half_q;
  logic                 div_start;
  logic [DIV_W-1:0]     div_dividend;
  logic                 div_done;
  logic [DIV_W-1:0]     div_quo;
  logic [MEAN_W-1:0]    quo_mean;

  logic signed [DRIFT_W+1:0] drift_off;
  logic                      cneg;
  logic [CPROD_W-1:0]        cmag;
  logic [CPROD_W:0]          cmag_rnd;
  logic [CORR_W-2:0]         crnd;

  logic signed [MEAN_W:0]        psum;
  logic [SQ_W+OCHG_W-1:0]        chg_ext;
  logic [CNT_W+OSIZE_W-1:0]      size_ext;

  assign in_stall   = (state_r != S_IDLE);
  assign in_accept  = in_valid && !in_stall;
  assign out_valid  = (state_r == S_OUT);
  assign out_accept = out_valid && !out_stall;

  // join decision against the open cluster
  always_comb begin
    chan_diff    = $signed({1'b0, in_strip_channel}) - $signed({1'b0, prev_channel_r});
    hole_lim     = $signed({{(CH_W+1-HOLE_W){1'b0}}, max_hole_r}) + $signed((CH_W+1)'(1));
    full         = open_size_r >= CNT_W'(MAX_CLUSTER_STRIPS);
    close_now    = (open_size_r != '0) && ((chan_diff > hole_lim) || full);
    lcnt_after   = (lcnt_r == LCNT_TWO) ? LCNT_TWO : lcnt_r + 1'b1;
    end_emit_now = in_layer_end && (lcnt_after == LCNT_TWO);
  end

  // divider operands
  always_comb begin
    spq_neg  = sum_pos_r[SPQ_W-1];
    spq_mag  = spq_neg ? SPQ_W'(-sum_pos_r) : SPQ_W'(sum_pos_r);
    half_q   = sum_charge_r >> 1;
    quo_mean = div_quo[MEAN_W-1:0];
    if (state_r == S_DSET) begin
      div_dividend = DIV_W'(spq_mag) + DIV_W'(half_q);
    end else begin
      div_dividend = DIV_W'(sum_drift_r) + DIV_W'(half_q);
    end
    div_start = ((state_r == S_DSET) && (sum_charge_r != '0)) ||
                ((state_r == S_DPOS) && div_done);
  end

  sctp_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (sum_charge_r),
    .done     (div_done),
    .quotient (div_quo)
  );

  // drift correction and saturation
  always_comb begin
    drift_off = $signed({2'b00, mean_drift_r}) - $signed({2'b00, half_gap_r});
    cneg      = cprod_r[CPROD_W-1];
    cmag      = cneg ? CPROD_W'(-cprod_r) : CPROD_W'(cprod_r);
    cmag_rnd  = {1'b0, cmag} + (CPROD_W+1)'(CRND_HALF);
    crnd      = cmag_rnd[CPROD_W:16];
    psum      = (MEAN_W+1)'(mean_pos_r) + (MEAN_W+1)'(corr_r);
    chg_ext   = (SQ_W+OCHG_W)'(sum_charge_r);
    size_ext  = (CNT_W+OSIZE_W)'(open_size_r);
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_accept) begin
          state_nxt = close_now ? S_DSET : S_MUL;
        end
      end
      S_MUL:  state_nxt = S_ACC;
      S_ACC: begin
        if (!end_r) begin
          state_nxt = S_IDLE;
        end else if (end_emit_r) begin
          state_nxt = S_DSET;
        end else begin
          state_nxt = S_CLR;
        end
      end
      S_DSET: state_nxt = (sum_charge_r == '0) ? S_CMUL : S_DPOS;
      S_DPOS: begin
        if (div_done) begin
          state_nxt = S_DDRF;
        end
      end
      S_DDRF: begin
        if (div_done) begin
          state_nxt = S_CMUL;
        end
      end
      S_CMUL: state_nxt = S_CRND;
      S_CRND: state_nxt = S_SAT;
      S_SAT:  state_nxt = S_OUT;
      S_OUT: begin
        if (out_accept) begin
          state_nxt = phase_r ? S_CLR : S_MUL;
        end
      end
      S_CLR:  state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= S_IDLE;
      max_hole_r      <= MAX_HOLE_RST;
      half_gap_r      <= HALF_GAP_RST;
      sum_pos_r       <= '0;
      sum_drift_r     <= '0;
      sum_charge_r    <= '0;
      prev_channel_r  <= '0;
      first_channel_r <= '0;
      open_size_r     <= '0;
      lcnt_r          <= '0;
      tan_h_r         <= '0;
      even_h_r        <= 1'b0;
      phase_r         <= 1'b0;
      end_r           <= 1'b0;
      end_emit_r      <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr_en) begin
        case (cfg_index)
          REG_MAX_HOLE: max_hole_r <= cfg_wdata[HOLE_W-1:0];
          REG_HALF_GAP: half_gap_r <= cfg_wdata[HGAP_W-1:0];
          default: ;
        endcase
      end
      case (state_r)
        S_IDLE: begin
          if (in_accept) begin
            prev_channel_r <= in_strip_channel;
            lcnt_r         <= lcnt_after;
            end_r          <= in_layer_end;
            end_emit_r     <= end_emit_now;
            phase_r        <= 1'b0;
          end
        end
        S_MUL: begin
          if (open_size_r == '0) begin
            first_channel_r <= ch_r;
            tan_h_r         <= tan_r;
            even_h_r        <= even_r;
          end
        end
        S_ACC: begin
          sum_pos_r    <= sum_pos_r + SPQ_W'(pprod_r);
          sum_drift_r  <= sum_drift_r + SDQ_W'(dprod_r);
          sum_charge_r <= sum_charge_r + SQ_W'(q_r);
          open_size_r  <= open_size_r + 1'b1;
          phase_r      <= 1'b1;
        end
        S_OUT: begin
          if (out_accept && !phase_r) begin
            sum_pos_r       <= '0;
            sum_drift_r     <= '0;
            sum_charge_r    <= '0;
            open_size_r     <= '0;
            first_channel_r <= '0;
            tan_h_r         <= '0;
            even_h_r        <= 1'b0;
          end
        end
        S_CLR: begin
          sum_pos_r       <= '0;
          sum_drift_r     <= '0;
          sum_charge_r    <= '0;
          open_size_r     <= '0;
          first_channel_r <= '0;
          tan_h_r         <= '0;
          even_h_r        <= 1'b0;
          prev_channel_r  <= '0;
          lcnt_r          <= '0;
        end
        default: ;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (in_accept) begin
      ch_r    <= in_strip_channel;
      pos_r   <= in_strip_pos;
      drift_r <= in_drift_dist;
      q_r     <= in_strip_charge;
      tan_r   <= in_tan_theta;
      even_r  <= in_even_gap;
    end
    if (state_r == S_MUL) begin
      pprod_r <= pos_r * $signed({1'b0, q_r});
      dprod_r <= drift_r * q_r;
    end
    if (state_r == S_DSET) begin
      neg_r        <= spq_neg;
      mean_pos_r   <= '0;
      mean_drift_r <= '0;
    end
    if ((state_r == S_DPOS) && div_done) begin
      mean_pos_r <= neg_r ? -$signed(quo_mean) : $signed(quo_mean);
    end
    if ((state_r == S_DDRF) && div_done) begin
      mean_drift_r <= div_quo[DRIFT_W-1:0];
    end
    if (state_r == S_CMUL) begin
      cprod_r <= tan_h_r * drift_off;
    end
    if (state_r == S_CRND) begin
      corr_r <= (cneg ^ even_h_r) ? -$signed({1'b0, crnd}) : $signed({1'b0, crnd});
    end
    if (state_r == S_SAT) begin
      if (psum > (MEAN_W+1)'(POS_MAX)) begin
        opos_r <= POS_W'(POS_MAX);
      end else if (psum < (MEAN_W+1)'(POS_MIN)) begin
        opos_r <= POS_W'(POS_MIN);
      end else begin
        opos_r <= psum[POS_W-1:0];
      end
      ochg_r   <= (chg_ext > (SQ_W+OCHG_W)'(OCHG_MAX)) ? OCHG_W'(OCHG_MAX)
                                                       : chg_ext[OCHG_W-1:0];
      osize_r  <= (size_ext > (CNT_W+OSIZE_W)'(OSIZE_MAX)) ? OSIZE_W'(OSIZE_MAX)
                                                           : size_ext[OSIZE_W-1:0];
      ofirst_r <= first_channel_r;
      olast_r  <= phase_r || !end_emit_r;
    end
  end

  assign out_cluster_position = opos_r;
  assign out_cluster_charge   = ochg_r;
  assign out_cluster_size     = osize_r;
  assign out_first_channel    = ofirst_r;
  assign out_last_of_run      = olast_r;

  `SCTP_ASSERT_NOW(a_no_take_while_result, !in_stall, !out_valid, "item taken while a result waits")
  `SCTP_ASSERT_NEXT(a_close_clears, out_accept && !phase_r, open_size_r == '0, "closed cluster not cleared")
  `SCTP_ASSERT_NOW(a_div_done_waited, div_done, (state_r == S_DPOS) || (state_r == S_DDRF), "divider result unclaimed")

endmodule

[src/sctp_div.sv]
// Serial restoring divider: one quotient bit per cycle, shared by both cluster means.
module sctp_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [sctp_pkg::DIV_W-1:0] dividend,
  input  logic [sctp_pkg::SQ_W-1:0]  divisor,
  output logic                       done,
  output logic [sctp_pkg::DIV_W-1:0] quotient
);
  import sctp_pkg::*;

  logic                 run_r;
  logic                 done_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic [SQ_W-1:0]      rem_r;
  logic [SQ_W-1:0]      rem_nxt;
  logic [DIV_W-1:0]     quo_r;
  logic [SQ_W:0]        trial;
  logic                 ge;

  always_comb begin
    trial   = {rem_r, quo_r[DIV_W-1]};
    ge      = trial >= {1'b0, divisor};
    rem_nxt = ge ? SQ_W'(trial - {1'b0, divisor}) : trial[SQ_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= '0;
      end else if (run_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == DIV_LAST) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= dividend;
    end else if (run_r) begin
      rem_r <= rem_nxt;
      quo_r <= {quo_r[DIV_W-2:0], ge};
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

[test/tb_strip_cluster_time_projection.sv]
// Testbench for strip_cluster_time_projection: directed table plus random layers, self-checked.
`timescale 1ns / 100ps

module tb_strip_cluster_time_projection;
  import sctp_pkg::*;

  typedef struct packed {
    logic [CH_W-1:0]           ch;
    logic signed [POS_W-1:0]   pos;
    logic [DRIFT_W-1:0]        drift;
    logic [CHG_W-1:0]          q;
    logic signed [TAN_W-1:0]   tan;
    logic                      even;
    logic                      lend;
  } strip_t;

  typedef struct packed {
    logic signed [POS_W-1:0]   pos;
    logic [OCHG_W-1:0]         chg;
    logic [OSIZE_W-1:0]        size;
    logic [CH_W-1:0]           first;
    logic                      last;
  } cluster_t;

  typedef struct packed {
    strip_t   s;
    logic     typed;
    cluster_t want;
  } row_t;

  localparam int DIR_N        = 23;
  localparam int PHASE_STRIPS = 78;
  localparam int HOLD_CYCLES  = 400;
  localparam int SETTLE       = 50;

  logic                      clk = 1'b0;
  logic                      rst_n;
  logic                      cfg_wr_en;
  logic [CFG_IDX_W-1:0]      cfg_index;
  logic [CFG_W-1:0]          cfg_wdata;
  logic                      in_valid;
  logic                      in_stall;
  logic [CH_W-1:0]           in_strip_channel;
  logic signed [POS_W-1:0]   in_strip_pos;
  logic [DRIFT_W-1:0]        in_drift_dist;
  logic [CHG_W-1:0]          in_strip_charge;
  logic signed [TAN_W-1:0]   in_tan_theta;
  logic                      in_even_gap;
  logic                      in_layer_end;
  logic                      out_valid;
  logic                      out_stall;
  logic signed [POS_W-1:0]   out_cluster_position;
  logic [OCHG_W-1:0]         out_cluster_charge;
  logic [OSIZE_W-1:0]        out_cluster_size;
  logic [CH_W-1:0]           out_first_channel;
  logic                      out_last_of_run;

  strip_cluster_time_projection u_dut (.*);

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  int       hole_cfg = int'(MAX_HOLE_RST);
  int       gap_cfg  = int'(HALF_GAP_RST);
  longint   acc_q, acc_pq, acc_dq;
  int       last_ch, open_cnt, layer_cnt;
  logic [CH_W-1:0]         open_first;
  logic signed [TAN_W-1:0] open_tan;
  logic                    open_even;

  cluster_t pending_clusters[$];
  int       mismatches;
  int       send_idle_pct, recv_idle_pct;
  int       hold_left;
  int       strips_sent;
  bit       typed_row;
  cluster_t typed_want;
  row_t     dir_rows [DIR_N];

  function automatic longint round_div(longint n, longint d);
    longint mag;
    mag = (n < 0) ? -n : n;
    mag = (mag + d / 2) / d;
    return (n < 0) ? -mag : mag;
  endfunction

  function automatic cluster_t finish_cluster();
    longint   mpos, mdrift, prod, mag, corr, p;
    cluster_t c;
    mpos = 0;
    mdrift = 0;
    if (acc_q != 0) begin
      mpos = round_div(acc_pq, acc_q);
      mdrift = round_div(acc_dq, acc_q);
    end
    prod = longint'(open_tan) * (mdrift - longint'(gap_cfg));
    mag = (prod < 0) ? -prod : prod;
    mag = (mag + 32768) / 65536;
    corr = (prod < 0) ? -mag : mag;
    if (open_even) corr = -corr;
    p = mpos + corr;
    if (p > POS_MAX) p = POS_MAX;
    if (p < POS_MIN) p = POS_MIN;
    c.pos = POS_W'(p);
    c.chg = (acc_q > OCHG_MAX) ? OCHG_W'(OCHG_MAX) : OCHG_W'(acc_q);
    c.size = (open_cnt > OSIZE_MAX) ? OSIZE_W'(OSIZE_MAX) : OSIZE_W'(open_cnt);
    c.first = open_first;
    c.last = 1'b0;
    return c;
  endfunction

  function automatic void clear_open();
    acc_q = 0;
    acc_pq = 0;
    acc_dq = 0;
    open_cnt = 0;
    open_first = '0;
    open_tan = '0;
    open_even = 1'b0;
  endfunction

  function automatic void project_strip(strip_t s);
    int       n_out;
    int       step;
    cluster_t c;
    n_out = 0;
    if (open_cnt > 0) begin
      step = int'(s.ch) - last_ch;
      if (!(step <= hole_cfg + 1 && open_cnt < MAX_CLUSTER_STRIPS)) begin
        pending_clusters.push_back(finish_cluster());
        n_out++;
        clear_open();
      end
    end
    if (open_cnt == 0) begin
      open_first = s.ch;
      open_tan = s.tan;
      open_even = s.even;
    end
    acc_q += longint'(s.q);
    acc_pq += longint'(s.pos) * longint'(s.q);
    acc_dq += longint'(s.drift) * longint'(s.q);
    open_cnt++;
    last_ch = int'(s.ch);
    if (layer_cnt < 2) layer_cnt++;
    if (s.lend) begin
      if (layer_cnt >= 2) begin
        pending_clusters.push_back(finish_cluster());
        n_out++;
      end
      clear_open();
      last_ch = 0;
      layer_cnt = 0;
    end
    if (n_out > 0) begin
      c = pending_clusters.pop_back();
      c.last = 1'b1;
      pending_clusters.push_back(c);
    end
  endfunction

  task automatic cmp_field(string name, longint want, longint got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      mismatches++;
    end
  endtask

  always @(negedge clk) begin
    strip_t   s;
    cluster_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_clusters.size() == 0) begin
        $display("%0t: unexpected cluster, expected none, actual pos %0d first %0d",
                 $time, out_cluster_position, out_first_channel);
        mismatches++;
      end else begin
        want = pending_clusters.pop_front();
        cmp_field("cluster_position", longint'(want.pos), longint'(out_cluster_position));
        cmp_field("cluster_charge", longint'(want.chg), longint'(out_cluster_charge));
        cmp_field("cluster_size", longint'(want.size), longint'(out_cluster_size));
        cmp_field("first_channel", longint'(want.first), longint'(out_first_channel));
        cmp_field("last_of_run", longint'(want.last), longint'(out_last_of_run));
      end
    end
    if (rst_n && in_valid && !in_stall) begin
      s = '{in_strip_channel, in_strip_pos, in_drift_dist, in_strip_charge,
            in_tan_theta, in_even_gap, in_layer_end};
      project_strip(s);
      if (typed_row) begin
        void'(pending_clusters.pop_back());
        pending_clusters.push_back(typed_want);
      end
    end
  end

  initial begin
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  task automatic send_strip(strip_t s, bit typed, cluster_t want);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_strip_channel <= s.ch;
    in_strip_pos <= s.pos;
    in_drift_dist <= s.drift;
    in_strip_charge <= s.q;
    in_tan_theta <= s.tan;
    in_even_gap <= s.even;
    in_layer_end <= s.lend;
    typed_row = typed;
    typed_want = want;
    @(negedge clk);
    while (in_stall) @(negedge clk);
    @(posedge clk);
    strips_sent++;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_clusters.size() != 0) @(posedge clk);
  endtask

  task automatic set_config(int hole, int gap);
    cfg_wr_en <= 1'b1;
    cfg_index <= REG_MAX_HOLE;
    cfg_wdata <= CFG_W'(($urandom_range(511) << HOLE_W) | hole);
    @(posedge clk);
    cfg_index <= REG_HALF_GAP;
    cfg_wdata <= CFG_W'(gap);
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    hole_cfg = hole;
    gap_cfg = gap;
  endtask

  function automatic strip_t random_content(int ch, logic signed [TAN_W-1:0] tan,
                                            logic even, int base, bit spread);
    strip_t s;
    int     pick;
    s.ch = CH_W'(ch);
    s.pos = spread ? POS_W'($urandom) : POS_W'(base + $urandom_range(400) - 200);
    s.drift = DRIFT_W'($urandom_range(8191));
    pick = $urandom_range(99);
    if (pick < 10) s.q = '0;
    else if (pick < 20) s.q = '1;
    else if (pick < 30) s.q = CHG_W'($urandom_range(8, 1));
    else s.q = CHG_W'($urandom_range(65535));
    s.tan = ($urandom_range(99) < 80) ? tan : TAN_W'($urandom);
    s.even = even;
    s.lend = 1'b0;
    return s;
  endfunction

  task automatic random_layer();
    int       n, k, pick, ch, base;
    bit       spread;
    logic signed [TAN_W-1:0] tan;
    logic     even;
    strip_t   s;
    pick = $urandom_range(99);
    if (pick < 8) n = 1;
    else if (pick < 75) n = $urandom_range(8, 2);
    else if (pick < 97) n = $urandom_range(24, 9);
    else n = $urandom_range(70, 60);
    ch = $urandom_range(8191);
    base = int'($urandom);
    spread = ($urandom_range(3) == 0);
    tan = ($urandom_range(9) == 0) ? TAN_W'($urandom_range(64)) : TAN_W'($urandom);
    even = 1'($urandom_range(1));
    for (k = 0; k < n; k++) begin
      if (k > 0) begin
        pick = $urandom_range(99);
        if (pick < 70) ch += $urandom_range(hole_cfg + 1, 1);
        else if (pick < 85) ch += hole_cfg + 2 + $urandom_range(20);
        else if (pick < 92) ch += 0;
        else ch -= $urandom_range(50, 1);
      end
      s = random_content(ch, tan, even, base, spread);
      s.lend = (k == n - 1);
      send_strip(s, 1'b0, '0);
    end
  endtask

  initial begin
    #20ms;
    $display("tb: failure");
    $finish;
  end

  initial begin
    strip_t   s;
    int       ph, k, phase_start;
    bit       paused;
    rst_n <= 1'b0;
    cfg_wr_en <= 1'b0;
    cfg_index <= '0;
    cfg_wdata <= '0;
    in_valid <= 1'b0;
    in_strip_channel <= '0;
    in_strip_pos <= '0;
    in_drift_dist <= '0;
    in_strip_charge <= '0;
    in_tan_theta <= '0;
    in_even_gap <= 1'b0;
    in_layer_end <= 1'b0;
    mismatches = 0;
    strips_sent = 0;
    hold_left = 0;
    typed_row = 1'b0;
    typed_want = '0;
    last_ch = 0;
    layer_cnt = 0;
    clear_open();
    send_idle_pct = 21;
    recv_idle_pct = 65;

    dir_rows = '{
      '{'{5,       0,    0,   100,      0, 0, 1}, 0, '{0, 0, 0, 0, 0}},
      '{'{10,      100,  0,   1,        0, 0, 0}, 0, '{0, 0, 0, 0, 0}},
      '{'{11,      100,  0,   1,        0, 0, 1}, 1, '{100, 2, 2, 10, 1}},
      '{'{20,      500,  3000, 0,    4096, 0, 0}, 0, '{0, 0, 0, 0, 0}},
      '{'{21,      -700, 100, 0,     4096, 0, 1}, 1, '{-161, 0, 2, 20, 1}},
      '{'{30,      500,  3000, 0,    4096, 1, 0}, 0, '{0, 0, 0, 0, 0}},
      '{'{31,      -700, 100, 0,     4096, 1, 1}, 1, '{161, 0, 2, 30, 1}},
      '{'{40,      1000, 5000, 300,  2000, 0, 0}, 0, '{0, 0, 0, 0, 0}},
      '{'{41,      1064, 5100, 200, -3000, 1, 0}, 0, '{0, 0, 0, 0, 0}},
      '{'{45,      1300, 200, 50,     700, 0, 1}, 0, '{0, 0, 0, 0, 0}},
      '{'{50,     -5000, 8191, 65535, 32767, 0, 0}, 0, '{0, 0, 0, 0, 0}},
      '{'{52,     -4936, 0,   1,        0, 0, 1}, 0, '{0, 0, 0, 0, 0}},
      '{'{60,      64,   8191, 65535, 32767, 1, 0}, 0, '{0, 0, 0, 0, 0}},
      '{'{58,      0,    8191, 65535, -32768, 0, 0}, 0, '{0, 0, 0, 0, 0}},
      '{'{58,      -64,  8191, 65535,     0, 0, 1}, 0, '{0, 0, 0, 0, 0}},
      '{'{8190, 2097151, 0, 65535, -32768, 0, 0}, 0, '{0, 0, 0, 0, 0}},
      '{'{8191, 2097151, 0, 65535, -32768, 0, 1}, 1, '{2097151, 131070, 2, 8190, 1}},
      '{'{0,   -2097152, 0, 65535,  32767, 0, 0}, 0, '{0, 0, 0, 0, 0}},
      '{'{1,   -2097152, 0, 65535,  32767, 0, 1}, 1, '{-2097152, 131070, 2, 0, 1}},
      '{'{100,     1,    0,   1,        0, 0, 0}, 0, '{0, 0, 0, 0, 0}},
      '{'{101,     2,    0,   1,        0, 0, 1}, 1, '{2, 2, 2, 100, 1}},
      '{'{200,     -1,   0,   1,        0, 0, 0}, 0, '{0, 0, 0, 0, 0}},
      '{'{201,     -2,   0,   1,        0, 0, 1}, 1, '{-2, 2, 2, 200, 1}}
    };

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i]) send_strip(dir_rows[i].s, dir_rows[i].typed, dir_rows[i].want);

    for (k = 0; k < 66; k++) begin
      s = random_content(1000 + k, TAN_W'($urandom), 1'($urandom_range(1)),
                         int'($urandom), 1'b0);
      s.lend = (k == 65);
      send_strip(s, 1'b0, '0);
    end

    for (ph = 0; ph < 6; ph++) begin
      wait_drained();
      repeat (SETTLE) @(posedge clk);
      case (ph)
        0: set_config(0, 0);
        1: set_config(15, 8191);
        default: set_config($urandom_range(15), $urandom_range(8191));
      endcase
      if (ph < 2) begin
        send_idle_pct = 21;
        recv_idle_pct = 65;
      end else if (ph < 4) begin
        send_idle_pct = 65;
        recv_idle_pct = 21;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      if (ph == 4) hold_left = HOLD_CYCLES;
      phase_start = strips_sent;
      paused = 1'b0;
      while (strips_sent - phase_start < PHASE_STRIPS) begin
        if (ph == 2 && !paused && strips_sent - phase_start >= PHASE_STRIPS / 2) begin
          wait_drained();
          paused = 1'b1;
        end
        random_layer();
      end
    end

    wait_drained();
    repeat (SETTLE) @(posedge clk);
    if (mismatches == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule
